@@ rtl/core/topt_pkg.sv @@
// Package for the three-opt tour improver: sizes, item kinds, datapath
// operation codes, controller/datapath command and status structs, tables.
// No dependencies.
package topt_pkg;

   // Sizes of the stores and derived widths.
   localparam int MAX_CITIES = 64;
   localparam int DIST_BITS  = 16;
   localparam int CITY_W     = $clog2(MAX_CITIES);
   localparam int CNT_W      = CITY_W + 1;
   localparam int DADDR_W    = 2 * CITY_W;
   localparam int SUM_W      = DIST_BITS + 2;
   localparam int ACC_W      = DIST_BITS + CITY_W + 1;
   localparam int LEN_W      = 22;
   localparam int CCOUNT_W   = 7;
   localparam int FIELD_W    = 6;
   localparam int NUM_ENDS   = 6;
   localparam int NUM_CASES  = 8;

   localparam logic [LEN_W-1:0]    LEN_MAX          = '1;
   localparam logic [CCOUNT_W-1:0] CITY_COUNT_RESET = 7'd64;

   // Item kinds.
   localparam logic [2:0] KIND_DIST_WR = 3'd0;
   localparam logic [2:0] KIND_TOUR_WR = 3'd1;
   localparam logic [2:0] KIND_LENGTH  = 3'd2;
   localparam logic [2:0] KIND_MOVE    = 3'd3;
   localparam logic [2:0] KIND_SLOT_RD = 3'd4;

   // Register index of the configuration port.
   localparam logic REG_CITY_COUNT = 1'b0;

   // Datapath operations issued by the controller.
   typedef enum logic [4:0] {
      OP_NONE, OP_DIST_WR, OP_TOUR_WR, OP_SLOT_RD, OP_SLOT_TAKE,
      OP_W0, OP_W1, OP_W2, OP_W3,
      OP_MCHK, OP_RA, OP_RD, OP_DA, OP_DD, OP_DEC,
      OP_CRA, OP_CWR, OP_BRA, OP_BWR
   } op_type;

   typedef struct packed {
      logic   latch;
      logic   emit;
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic walk_last;
      logic cut_bad;
      logic read_last;
      logic sum_last;
      logic take_move;
      logic copy_last;
      logic back_last;
   } dp_stat_type;

   // End cities are kept as s0..s5 = tour[a], tour[b], tour[c],
   // tour[a+1], tour[b+1], tour[c+1]. Each case sums the distances of its end pairs.
   localparam logic [2:0] COST_PAIRS [NUM_CASES][NUM_ENDS] = '{
      '{3'd0, 3'd3, 3'd1, 3'd4, 3'd2, 3'd5},
      '{3'd0, 3'd3, 3'd1, 3'd2, 3'd4, 3'd5},
      '{3'd0, 3'd1, 3'd3, 3'd4, 3'd2, 3'd5},
      '{3'd0, 3'd1, 3'd3, 3'd2, 3'd4, 3'd5},
      '{3'd0, 3'd4, 3'd2, 3'd3, 3'd1, 3'd5},
      '{3'd0, 3'd4, 3'd2, 3'd1, 3'd3, 3'd5},
      '{3'd0, 3'd2, 3'd4, 3'd3, 3'd1, 3'd5},
      '{3'd0, 3'd2, 3'd4, 3'd1, 3'd3, 3'd5}
   };

   // Where the n-th tour read of a move lands among s0..s5.
   localparam logic [2:0] READ_SLOT [NUM_ENDS] = '{
      3'd0, 3'd3, 3'd1, 3'd4, 3'd2, 3'd5
   };

   // Successor of a tour position on a closed tour of n cities.
   function automatic logic [CNT_W-1:0] next_pos(input logic [CNT_W-1:0] i,
                                                 input logic [CNT_W-1:0] n);
      logic [CNT_W:0] inc;
      inc = {1'b0, i} + 1'b1;
      next_pos = (inc < {1'b0, n}) ? inc[CNT_W-1:0] : '0;
   endfunction

endpackage

@@ rtl/core/topt_ifs.sv @@
// Handshake channels of the three-opt tour improver: item request and result.
// Depends on topt_pkg.
interface topt_req_if import topt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic [FIELD_W-1:0] row_city;
   logic [FIELD_W-1:0] col_city;
   logic [15:0]        distance;
   logic [FIELD_W-1:0] slot;
   logic [FIELD_W-1:0] city;
   logic [FIELD_W-1:0] cut_a;
   logic [FIELD_W-1:0] cut_b;
   logic [FIELD_W-1:0] cut_c;

   modport source (output valid, kind, row_city, col_city, distance, slot, city,
                   cut_a, cut_b, cut_c, input ready);
   modport sink (input valid, kind, row_city, col_city, distance, slot, city,
                 cut_a, cut_b, cut_c, output ready);
endinterface

interface topt_rsp_if import topt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               status;
   logic [LEN_W-1:0]   tour_length;
   logic [2:0]         choice;
   logic [FIELD_W-1:0] city_out;

   modport source (output valid, status, tour_length, choice, city_out, input ready);
   modport sink (input valid, status, tour_length, choice, city_out, output ready);
endinterface

@@ rtl/core/three_opt_tour_improver_top.sv @@
// Top level of the three-opt tour improver: configuration register port,
// controller and datapath. Depends on topt_pkg, topt_ifs, topt_ctrl, topt_dp.
//
//   Channel   Direction  Carries
//   req_ch    in         one item: kind, distance entry, slot/city, three cuts
//   rsp_ch    out        one result per item: status, length, choice, city
//   csr_*     in/out     APB register city_count at byte address 0
//
// One item at a time. A length walk does one tour read and one distance read per
// city. A move reads the six end cities and forms the eight case sums; when the
// move is applied, it then copies the tour slot by slot into the scratch memory
// and back into the tour memory. Reset clears the controller and the length, and
// sets city_count to 64; the memories are not cleared. A held result does not block the
// next item; an item waits only to hand over its own result.
module three_opt_tour_improver_top import topt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   topt_req_if.sink      req_ch,
   topt_rsp_if.source    rsp_ch,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   logic [CCOUNT_W-1:0] city_count_ff, city_count_in;
   logic                csr_wr;
   dp_cmd_type          cmd;
   dp_stat_type         stat;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_CITY_COUNT) ? 32'(city_count_ff) : '0;

   always_comb begin
      city_count_in = city_count_ff;
      if (csr_wr && (csr_paddr[2] == REG_CITY_COUNT)) begin
         city_count_in = csr_pwdata[CCOUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= CITY_COUNT_RESET;
      end else begin
         city_count_ff <= city_count_in;
      end
   end

   topt_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_kind(req_ch.kind), .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .cmd(cmd), .stat(stat)
   );

   topt_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .city_count(city_count_ff),
      .in_row_city(req_ch.row_city), .in_col_city(req_ch.col_city),
      .in_distance(req_ch.distance), .in_slot(req_ch.slot), .in_city(req_ch.city),
      .in_cut_a(req_ch.cut_a), .in_cut_b(req_ch.cut_b), .in_cut_c(req_ch.cut_c),
      .out_status(rsp_ch.status), .out_tour_length(rsp_ch.tour_length),
      .out_choice(rsp_ch.choice), .out_city_out(rsp_ch.city_out)
   );

   // An accepted item keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("block took a second item right after accepting one");

   // A new result appears only from a busy block.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(!req_ch.ready))
      else $error("result appeared without an item in work");

   // A register write lands in city_count.
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr && (csr_paddr[2] == REG_CITY_COUNT)
      |=> city_count_ff == $past(csr_pwdata[CCOUNT_W-1:0]))
      else $error("city_count did not take the written value");
endmodule

@@ rtl/core/topt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module topt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/topt_dp.sv @@
// Datapath of the three-opt tour improver: distance, tour and scratch memories,
// walk and move arithmetic, segment copy counters and the result register.
// Depends on topt_pkg and topt_ram.
module topt_dp import topt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   input  logic [CCOUNT_W-1:0] city_count,
   input  logic [FIELD_W-1:0]  in_row_city,
   input  logic [FIELD_W-1:0]  in_col_city,
   input  logic [15:0]         in_distance,
   input  logic [FIELD_W-1:0]  in_slot,
   input  logic [FIELD_W-1:0]  in_city,
   input  logic [FIELD_W-1:0]  in_cut_a,
   input  logic [FIELD_W-1:0]  in_cut_b,
   input  logic [FIELD_W-1:0]  in_cut_c,
   output logic                out_status,
   output logic [LEN_W-1:0]    out_tour_length,
   output logic [2:0]          out_choice,
   output logic [FIELD_W-1:0]  out_city_out
);
   // Latched item fields.
   logic [CITY_W-1:0]    row_ff, row_in, col_ff, col_in;
   logic [DIST_BITS-1:0] dist_ff, dist_in;
   logic [CITY_W-1:0]    slot_ff, slot_in, city_ff, city_in;
   logic [CITY_W-1:0]    ca_ff, ca_in, cb_ff, cb_in, cc_ff, cc_in;
   logic [CNT_W-1:0]     n_ff, n_in;

   // Working state.
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CITY_W-1:0] prev_ff, prev_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [CITY_W-1:0] s_ff [NUM_ENDS];
   logic [CITY_W-1:0] s_in [NUM_ENDS];
   logic [2:0]        k_ff, k_in;
   logic [1:0]        j_ff, j_in;
   logic [SUM_W-1:0]  sacc_ff, sacc_in, sum0_ff, sum0_in, best_ff, best_in;
   logic [2:0]        bidx_ff, bidx_in;
   logic [CNT_W-1:0]  w_ff, w_in;
   logic [1:0]        seg_ff, seg_in;
   logic [CITY_W-1:0] p_ff, p_in, end_ff, end_in;
   logic              dir_ff, dir_in;

   // Per-item result and the output register.
   logic              res_status_ff, res_status_in;
   logic [2:0]        res_choice_ff, res_choice_in;
   logic [CITY_W-1:0] res_city_ff, res_city_in;
   logic              o_status_ff, o_status_in;
   logic [LEN_W-1:0]  o_len_ff, o_len_in;
   logic [2:0]        o_choice_ff, o_choice_in;
   logic [CITY_W-1:0] o_city_ff, o_city_in;

   // Memory ports.
   logic                 d_we, t_we, s_we;
   logic [DADDR_W-1:0]   d_wa, d_ra;
   logic [DIST_BITS-1:0] d_rd;
   logic [CITY_W-1:0]    t_wa, t_wd, t_ra, t_rd, s_wa, s_wd, s_ra, s_rd;

   // Helper values.
   logic [ACC_W-1:0]  walk_sum;
   logic [SUM_W-1:0]  case_sum;
   logic [LEN_W+1:0]  move_len;
   logic [LEN_W-1:0]  move_sat;
   logic [2:0]        q0, q1;
   logic [1:0]        seg_sel;
   logic [CITY_W-1:0] seg_lo, seg_hi;
   logic              seg_rev;
   logic [CITY_W-1:0] n_last;

   topt_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_CITIES * MAX_CITIES)) u_dist_ram (
      .clock(clock), .wr_en(d_we), .wr_addr(d_wa), .wr_data(dist_ff),
      .rd_addr(d_ra), .rd_data(d_rd)
   );
   topt_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_tour_ram (
      .clock(clock), .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd),
      .rd_addr(t_ra), .rd_data(t_rd)
   );
   topt_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_scratch_ram (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd)
   );

   // Status back to the controller.
   always_comb begin
      stat.n_zero    = (n_ff == '0);
      stat.walk_last = (idx_ff == n_ff - 1'b1);
      stat.cut_bad   = ({1'b0, ca_ff} + 1'b1 >= {1'b0, cb_ff})
                    || ({1'b0, cb_ff} + 1'b1 >= {1'b0, cc_ff})
                    || ({1'b0, cc_ff} + 1'b1 >= n_ff);
      stat.read_last = (idx_ff == CNT_W'(NUM_ENDS - 1));
      stat.sum_last  = (j_ff == 2'd2) && (k_ff == 3'(NUM_CASES - 1));
      stat.take_move = (best_ff <= sum0_ff);
      stat.copy_last = (p_ff == end_ff)
                    && ((seg_ff == 2'd3) || ((seg_ff == 2'd2) && (ca_ff == '0)));
      stat.back_last = (idx_ff == n_ff - 1'b1);
   end

   // Arithmetic of the walk and the move.
   always_comb begin
      n_last   = CITY_W'(n_ff - 1'b1);
      walk_sum = acc_ff + ACC_W'(d_rd);
      case_sum = sacc_ff + SUM_W'(d_rd);
      move_len = {2'b00, len_ff} + (LEN_W+2)'(best_ff) - (LEN_W+2)'(sum0_ff);
      if (move_len[LEN_W+1]) begin
         move_sat = '0;
      end else if (move_len[LEN_W]) begin
         move_sat = LEN_MAX;
      end else begin
         move_sat = move_len[LEN_W-1:0];
      end
      q0 = COST_PAIRS[k_ff][{j_ff, 1'b0}];
      q1 = COST_PAIRS[k_ff][{j_ff, 1'b1}];
   end

   // Bounds of the next segment to copy into scratch.
   always_comb begin
      seg_sel = (cmd.op == OP_DEC) ? 2'd0 : seg_ff + 2'd1;
      seg_lo  = '0;
      seg_hi  = '0;
      seg_rev = 1'b0;
      case (seg_sel)
         2'd0: begin
            seg_lo  = bidx_ff[2] ? cb_ff + 1'b1 : ca_ff + 1'b1;
            seg_hi  = bidx_ff[2] ? cc_ff : cb_ff;
            seg_rev = bidx_ff[1];
         end
         2'd1: begin
            seg_lo  = bidx_ff[2] ? ca_ff + 1'b1 : cb_ff + 1'b1;
            seg_hi  = bidx_ff[2] ? cb_ff : cc_ff;
            seg_rev = bidx_ff[0];
         end
         2'd2: begin
            seg_lo = cc_ff + 1'b1;
            seg_hi = n_last;
         end
         default: begin
            seg_lo = '0;
            seg_hi = ca_ff - 1'b1;
         end
      endcase
   end

   // Memory addresses and write enables per operation.
   always_comb begin
      d_we = 1'b0;
      d_wa = {row_ff, col_ff};
      d_ra = '0;
      t_we = 1'b0;
      t_wa = slot_ff;
      t_wd = city_ff;
      t_ra = '0;
      s_we = 1'b0;
      s_wa = w_ff[CITY_W-1:0];
      s_wd = t_rd;
      s_ra = idx_ff[CITY_W-1:0];
      case (cmd.op)
         OP_DIST_WR: d_we = 1'b1;
         OP_TOUR_WR: t_we = 1'b1;
         OP_SLOT_RD: t_ra = slot_ff;
         OP_W0:      t_ra = '0;
         OP_W1:      t_ra = CITY_W'(next_pos('0, n_ff));
         OP_W2:      d_ra = {prev_ff, t_rd};
         OP_W3:      t_ra = CITY_W'(next_pos(idx_ff + 1'b1, n_ff));
         OP_RA: begin
            case (idx_ff[2:0])
               3'd0:    t_ra = ca_ff;
               3'd1:    t_ra = ca_ff + 1'b1;
               3'd2:    t_ra = cb_ff;
               3'd3:    t_ra = cb_ff + 1'b1;
               3'd4:    t_ra = cc_ff;
               default: t_ra = cc_ff + 1'b1;
            endcase
         end
         OP_DA:  d_ra = {s_ff[q0], s_ff[q1]};
         OP_DEC: begin
            s_we = stat.take_move;
            s_wa = '0;
            s_wd = s_ff[0];
         end
         OP_CRA: t_ra = p_ff;
         OP_CWR: s_we = 1'b1;
         OP_BWR: begin
            t_we = 1'b1;
            t_wa = idx_ff[CITY_W-1:0];
            t_wd = s_rd;
         end
         default: ;
      endcase
   end

   // Next values of the datapath registers.
   always_comb begin
      row_in = row_ff;   col_in = col_ff;   dist_in = dist_ff;
      slot_in = slot_ff; city_in = city_ff;
      ca_in = ca_ff;     cb_in = cb_ff;     cc_in = cc_ff;   n_in = n_ff;
      len_in = len_ff;   idx_in = idx_ff;   prev_in = prev_ff; acc_in = acc_ff;
      s_in = s_ff;
      k_in = k_ff;       j_in = j_ff;       sacc_in = sacc_ff;
      sum0_in = sum0_ff; best_in = best_ff; bidx_in = bidx_ff;
      w_in = w_ff;       seg_in = seg_ff;   p_in = p_ff;  end_in = end_ff;
      dir_in = dir_ff;
      res_status_in = res_status_ff; res_choice_in = res_choice_ff;
      res_city_in = res_city_ff;
      o_status_in = o_status_ff; o_len_in = o_len_ff;
      o_choice_in = o_choice_ff; o_city_in = o_city_ff;

      // Capture the item and clear its result.
      if (cmd.latch) begin
         row_in  = in_row_city;
         col_in  = in_col_city;
         dist_in = in_distance[DIST_BITS-1:0];
         slot_in = in_slot;
         city_in = in_city;
         ca_in   = in_cut_a;
         cb_in   = in_cut_b;
         cc_in   = in_cut_c;
         n_in    = (city_count > CCOUNT_W'(MAX_CITIES)) ? CNT_W'(MAX_CITIES)
                                                       : CNT_W'(city_count);
         res_status_in = 1'b0;
         res_choice_in = '0;
         res_city_in   = '0;
      end

      case (cmd.op)
         OP_SLOT_TAKE: res_city_in = t_rd;
         OP_W0: begin
            idx_in = '0;
            acc_in = '0;
            if (n_ff == '0) begin
               len_in = '0;
            end
         end
         OP_W1: prev_in = t_rd;
         OP_W2: prev_in = t_rd;
         OP_W3: begin
            acc_in = walk_sum;
            if (stat.walk_last) begin
               len_in = (walk_sum > ACC_W'(LEN_MAX)) ? LEN_MAX : walk_sum[LEN_W-1:0];
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         OP_MCHK: begin
            res_status_in = stat.cut_bad;
            idx_in  = '0;
            k_in    = '0;
            j_in    = '0;
            sacc_in = '0;
         end
         OP_RD: begin
            s_in[READ_SLOT[idx_ff[2:0]]] = t_rd;
            idx_in = idx_ff + 1'b1;
         end
         OP_DD: begin
            if (j_ff == 2'd2) begin
               sacc_in = '0;
               j_in    = '0;
               k_in    = k_ff + 1'b1;
               // Case zero is the original tour; later cases keep the first minimum.
               if (k_ff == 3'd0) begin
                  sum0_in = case_sum;
               end else if ((k_ff == 3'd1) || (case_sum < best_ff)) begin
                  best_in = case_sum;
                  bidx_in = k_ff;
               end
            end else begin
               sacc_in = case_sum;
               j_in    = j_ff + 1'b1;
            end
         end
         OP_DEC: begin
            if (stat.take_move) begin
               res_choice_in = bidx_ff;
            end
            w_in   = CNT_W'(1);
            seg_in = 2'd0;
            p_in   = seg_rev ? seg_hi : seg_lo;
            end_in = seg_rev ? seg_lo : seg_hi;
            dir_in = seg_rev;
            idx_in = '0;
         end
         OP_CWR: begin
            w_in = w_ff + 1'b1;
            if (p_ff == end_ff) begin
               seg_in = seg_sel;
               p_in   = seg_rev ? seg_hi : seg_lo;
               end_in = seg_rev ? seg_lo : seg_hi;
               dir_in = seg_rev;
            end else begin
               p_in = dir_ff ? p_ff - 1'b1 : p_ff + 1'b1;
            end
         end
         OP_BWR: begin
            idx_in = idx_ff + 1'b1;
            if (stat.back_last) begin
               len_in = move_sat;
            end
         end
         default: ;
      endcase

      // Load the output register when the result goes out.
      if (cmd.emit) begin
         o_status_in = res_status_ff;
         o_len_in    = len_ff;
         o_choice_in = res_choice_ff;
         o_city_in   = res_city_ff;
      end
   end

   // Only the tour length has a reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;   col_ff <= col_in;   dist_ff <= dist_in;
      slot_ff <= slot_in; city_ff <= city_in;
      ca_ff <= ca_in;     cb_ff <= cb_in;     cc_ff <= cc_in;   n_ff <= n_in;
      idx_ff <= idx_in;   prev_ff <= prev_in; acc_ff <= acc_in;
      s_ff <= s_in;
      k_ff <= k_in;       j_ff <= j_in;       sacc_ff <= sacc_in;
      sum0_ff <= sum0_in; best_ff <= best_in; bidx_ff <= bidx_in;
      w_ff <= w_in;       seg_ff <= seg_in;   p_ff <= p_in;  end_ff <= end_in;
      dir_ff <= dir_in;
      res_status_ff <= res_status_in; res_choice_ff <= res_choice_in;
      res_city_ff <= res_city_in;
      o_status_ff <= o_status_in; o_len_ff <= o_len_in;
      o_choice_ff <= o_choice_in; o_city_ff <= o_city_in;
   end

   assign out_status      = o_status_ff;
   assign out_tour_length = o_len_ff;
   assign out_choice      = o_choice_ff;
   assign out_city_out    = o_city_ff;
endmodule

@@ rtl/core/topt_ctrl.sv @@
// Controller of the three-opt tour improver: one-hot sequencer over the item
// kinds, request/result handshakes and the result valid flag.
// Depends on topt_pkg.
module topt_ctrl import topt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [2:0]  req_kind,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);
   typedef enum logic [19:0] {
      ST_IDLE = 20'd1,      ST_DWR = 20'd2,       ST_TWR = 20'd4,
      ST_RRD  = 20'd8,      ST_RTK = 20'd16,      ST_W0  = 20'd32,
      ST_W1   = 20'd64,     ST_W2  = 20'd128,     ST_W3  = 20'd256,
      ST_MCHK = 20'd512,    ST_RA  = 20'd1024,    ST_RD  = 20'd2048,
      ST_DA   = 20'd4096,   ST_DD  = 20'd8192,    ST_DEC = 20'd16384,
      ST_CRA  = 20'd32768,  ST_CWR = 20'd65536,   ST_BRA = 20'd131072,
      ST_BWR  = 20'd262144, ST_DONE = 20'd524288
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Commands and next state.
   always_comb begin
      cmd.latch    = (state_ff == ST_IDLE) && req_valid;
      cmd.emit     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
      cmd.op       = OP_NONE;
      state_in     = state_ff;
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_DIST_WR: state_in = ST_DWR;
                  KIND_TOUR_WR: state_in = ST_TWR;
                  KIND_LENGTH:  state_in = ST_W0;
                  KIND_MOVE:    state_in = ST_MCHK;
                  KIND_SLOT_RD: state_in = ST_RRD;
                  default:      state_in = ST_DONE;
               endcase
            end
         end
         ST_DWR: begin
            cmd.op   = OP_DIST_WR;
            state_in = ST_DONE;
         end
         ST_TWR: begin
            cmd.op   = OP_TOUR_WR;
            state_in = ST_DONE;
         end
         ST_RRD: begin
            cmd.op   = OP_SLOT_RD;
            state_in = ST_RTK;
         end
         ST_RTK: begin
            cmd.op   = OP_SLOT_TAKE;
            state_in = ST_DONE;
         end
         // Length walk: read a city, read the edge distance, accumulate.
         ST_W0: begin
            cmd.op   = OP_W0;
            state_in = stat.n_zero ? ST_DONE : ST_W1;
         end
         ST_W1: begin
            cmd.op   = OP_W1;
            state_in = ST_W2;
         end
         ST_W2: begin
            cmd.op   = OP_W2;
            state_in = ST_W3;
         end
         ST_W3: begin
            cmd.op   = OP_W3;
            state_in = stat.walk_last ? ST_DONE : ST_W2;
         end
         // Move: check cuts, read six end cities, sum eight cases.
         ST_MCHK: begin
            cmd.op   = OP_MCHK;
            state_in = stat.cut_bad ? ST_DONE : ST_RA;
         end
         ST_RA: begin
            cmd.op   = OP_RA;
            state_in = ST_RD;
         end
         ST_RD: begin
            cmd.op   = OP_RD;
            state_in = stat.read_last ? ST_DA : ST_RA;
         end
         ST_DA: begin
            cmd.op   = OP_DA;
            state_in = ST_DD;
         end
         ST_DD: begin
            cmd.op   = OP_DD;
            state_in = stat.sum_last ? ST_DEC : ST_DA;
         end
         ST_DEC: begin
            cmd.op   = OP_DEC;
            state_in = stat.take_move ? ST_CRA : ST_DONE;
         end
         // Rebuild the tour in scratch, then copy it back.
         ST_CRA: begin
            cmd.op   = OP_CRA;
            state_in = ST_CWR;
         end
         ST_CWR: begin
            cmd.op   = OP_CWR;
            state_in = stat.copy_last ? ST_BRA : ST_CRA;
         end
         ST_BRA: begin
            cmd.op   = OP_BRA;
            state_in = ST_BWR;
         end
         ST_BWR: begin
            cmd.op   = OP_BWR;
            state_in = stat.back_last ? ST_DONE : ST_BRA;
         end
         ST_DONE: begin
            if (cmd.emit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
